FILE: design/indexed_sequence_store_top_assert.svh
// Assertion macros for the indexed sequence store.
// Used by iss_ctrl.sv and iss_datapath.sv; expects clk and rst_n in scope.
`ifndef INDEXED_SEQUENCE_STORE_TOP_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iss assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iss assertion failed");

`endif

FILE: design/iss_pkg.sv
// Package for the indexed sequence store: payload structs, codes, sizes.
// No dependencies.
`default_nettype none

package iss_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int VAL_W = 64;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] index;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] entry_count;
        logic [1:0]       status;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture the request
        logic exec;   // apply it and register the result
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/indexed_sequence_store_top.sv
// Indexed sequence store: an ordered list of up to 16 words of 64 bits,
// with insert, remove and read at a position. Uses iss_pkg, iss_ctrl,
// iss_datapath.
//
// Channels: req (req_valid / req_ready, payload req: mode, index, value)
// and rsp (rsp_valid / rsp_ready, payload rsp: read_value, entry_count,
// status). A transfer happens on a rising edge with valid and ready high.
// Every request yields exactly one response, in order.
//
// The request is captured on its transfer edge and applied in the execute
// state; rsp_valid rises when the result enters the output register. The
// controller alternates between taking a request and applying it to the
// shift cells, which move all entries in the same cycle on insert or remove.
//
// The response sits in an output register, so a new request is taken while
// an earlier response still waits. If the receiver stalls, the next request
// is held in the execute step until the output register frees up.
//
// Reset: the entry count goes to zero and both channels go idle. Entry
// contents are not cleared; only written entries are ever read back.
`default_nettype none

module indexed_sequence_store_top
    import iss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    cmd_t cmd;

    iss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    iss_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

FILE: design/iss_ctrl.sv
// Controller for the indexed sequence store: accept / execute sequencing
// and the response valid flag. Depends on iss_pkg and the assert header.
`default_nettype none

`include "indexed_sequence_store_top_assert.svh"

module iss_ctrl
    import iss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result slot free, or freed by this transfer
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `ISS_ASSERT_NEXT(a_accept_goes_exec, req_valid && req_ready, state_reg == S_EXEC)
    `ISS_ASSERT_NEXT(a_exec_gives_rsp, cmd.exec, rsp_valid_reg && state_reg == S_IDLE)
    `ISS_ASSERT_NOW(a_no_overwrite, cmd.exec, !rsp_valid_reg || rsp_ready)

endmodule

`default_nettype wire

FILE: design/iss_datapath.sv
// Datapath for the indexed sequence store: shift cells, entry count,
// request and response registers. Depends on iss_pkg and the assert header.
`default_nettype none

`include "indexed_sequence_store_top_assert.svh"

module iss_datapath
    import iss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire req_t req,
    output rsp_t      rsp
);

    req_t             item_reg;
    logic [VAL_W-1:0] entries_reg [DEPTH];
    logic [VAL_W-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    rsp_t             rsp_reg, rsp_next;

    logic ins_ok, rem_ok, rd_ok, full;

    always_comb
    begin
        full   = (count_reg == CNT_W'(DEPTH));
        ins_ok = (item_reg.mode == MODE_INSERT) && (item_reg.index <= count_reg) && !full;
        rem_ok = (item_reg.mode == MODE_REMOVE) && (item_reg.index < count_reg);
        rd_ok  = (item_reg.mode == MODE_READ) && (item_reg.index < count_reg);
    end

    // Shift cells: each cell looks only at its neighbors.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            entries_next[k] = entries_reg[k];
            if (ins_ok)
            begin
                if (CNT_W'(k) == item_reg.index)
                begin
                    entries_next[k] = item_reg.value;
                end
                else if (k > 0 && CNT_W'(k) > item_reg.index)
                begin
                    entries_next[k] = entries_reg[(k > 0) ? k - 1 : 0];
                end
            end
            else if (rem_ok && k < DEPTH - 1 && CNT_W'(k) >= item_reg.index)
            begin
                entries_next[k] = entries_reg[(k < DEPTH - 1) ? k + 1 : k];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_next.read_value  = rd_ok ? entries_reg[item_reg.index[IDX_W-1:0]] : '0;
        rsp_next.entry_count = count_next;
        if (ins_ok || rem_ok || rd_ok)
        begin
            rsp_next.status = ST_OK;
        end
        else if (item_reg.mode == MODE_INSERT && item_reg.index <= count_reg)
        begin
            rsp_next.status = ST_FULL;
        end
        else
        begin
            rsp_next.status = ST_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
            for (int k = 0; k < DEPTH; k++)
            begin
                entries_reg[k] <= entries_next[k];
            end
        end
    end

    assign rsp = rsp_reg;

    `ISS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for indexed_sequence_store_top: a short directed table, then biased random requests.
// Every response is checked against a behavioral model of the ordered list or a typed table row.
// Depends on iss_pkg and the RTL of the block.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iss_pkg::*;

    // The package names modes 0..2 only; 3 has no meaning and must be rejected.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int DIR_ROW_COUNT = 27;
    localparam int SEGMENT_LEN   = 80;
    localparam int SEGMENTS      = 20;      // 20 x 80 = 1600 random requests
    localparam int CALM_SEGMENTS = 2;       // last segments run with no idling
    localparam int TAIL_CYCLES   = 8;       // response comes after the execute state, from the output register
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [VAL_W-1:0] ONES = '1;

    // One row of the directed table. When typed is set, want is the response
    // read straight off the spec; otherwise the list model supplies it.
    typedef struct packed {
        req_t item;
        logic typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Behavioral copy of the list: words in order, entry 0 is the front.
    logic [VAL_W-1:0] list_words [DEPTH];
    logic [CNT_W-1:0] list_count;

    rsp_t     expected_rsp [$];
    rsp_t     want_rsp;
    dir_row_t dir_rows [DIR_ROW_COUNT];
    int       error_count  = 0;
    int       tx_gap_pct   = 10;
    int       rx_stall_pct = 10;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    indexed_sequence_store_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Applies one request to the list model and returns the response it must give.
    // Range is checked before fullness, so an insert past the end of a full
    // list reports out of range, not full.
    function automatic rsp_t predict_list_response(input req_t r);
        rsp_t o;
        int   k;
        o        = '0;
        o.status = ST_RANGE;
        case (r.mode)
            MODE_INSERT:
            begin
                if (r.index > list_count)
                    o.status = ST_RANGE;
                else if (list_count >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    for (k = int'(list_count); k > int'(r.index); k--)
                        list_words[k] = list_words[k-1];
                    list_words[r.index[IDX_W-1:0]] = r.value;
                    list_count          = list_count + 1'b1;
                    o.status            = ST_OK;
                end
            end
            MODE_REMOVE:
            begin
                if (r.index < list_count)
                begin
                    for (k = int'(r.index); k + 1 < int'(list_count); k++)
                        list_words[k] = list_words[k+1];
                    list_count = list_count - 1'b1;
                    o.status   = ST_OK;
                end
            end
            MODE_READ:
            begin
                if (r.index < list_count)
                begin
                    o.read_value = list_words[r.index[IDX_W-1:0]];
                    o.status     = ST_OK;
                end
            end
            default:
            begin
                o.status = ST_RANGE;
            end
        endcase
        o.entry_count = list_count;
        return o;
    endfunction

    // Draws one random request. Mostly legal positions with a bias toward the
    // two ends (deque use); a small share is raw noise over every mode and index.
    function automatic req_t pick_request(input int insert_pct, input int remove_pct);
        req_t r;
        int   roll;
        int   hi;
        r = '0;
        if ($urandom_range(99) < 5)
        begin
            r.mode  = 2'($urandom_range(3));
            r.index = CNT_W'($urandom_range(31));
            r.value = {$urandom, $urandom};
            return r;
        end
        roll = $urandom_range(99);
        if (roll < insert_pct)
            r.mode = MODE_INSERT;
        else if (roll < insert_pct + remove_pct)
            r.mode = MODE_REMOVE;
        else
            r.mode = MODE_READ;
        // last legal position; on an empty list remove/read at 0 hits the error path
        hi = (r.mode == MODE_INSERT) ? int'(list_count) : int'(list_count) - 1;
        if (hi < 0)
            hi = 0;
        case ($urandom_range(9))
            0, 1, 2: r.index = '0;
            3, 4, 5: r.index = CNT_W'(hi);
            default: r.index = CNT_W'($urandom_range(hi));
        endcase
        case ($urandom_range(9))
            0:       r.value = '0;
            1:       r.value = ONES;
            2:       r.value = 64'd1 << $urandom_range(63);
            default: r.value = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // Puts one request on the channel, holds it until the transfer, then records
    // the expected response and maybe idles for a burst.
    task automatic send_request(input req_t item, input logic typed, input rsp_t want);
        rsp_t predicted;
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = predict_list_response(item);
        expected_rsp.push_back(typed ? want : predicted);
        if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clk);
        end
    endtask

    // Sender holds off until every outstanding response has come back.
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Response checker: values are sampled at the edge, before any update.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response with none expected: read_value %h entry_count %0d status %0d",
                       rsp.read_value, rsp.entry_count, rsp.status);
                error_count++;
            end
            else
            begin
                want_rsp = expected_rsp.pop_front();
                if (rsp.read_value !== want_rsp.read_value)
                begin
                    $error("read_value: expected %h, got %h", want_rsp.read_value,
                           rsp.read_value);
                    error_count++;
                end
                if (rsp.entry_count !== want_rsp.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want_rsp.entry_count,
                           rsp.entry_count);
                    error_count++;
                end
                if (rsp.status !== want_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
                    error_count++;
                end
            end
        end
    end

    // Receiver: ready drops for bursts of random length at the current stall rate.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct)
                stall_left = $urandom_range(14, 1);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL indexed_sequence_store_top");
        $finish;
    end

    initial
    begin : stimulus
        int seg;
        int n;
        int insert_pct;
        int remove_pct;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        foreach (list_words[i])
            list_words[i] = '0;
        list_count = '0;

        // Directed table: empty-list errors, the unused mode, both value extremes,
        // a fill to capacity through inserts at front, back and middle, then the
        // full case and the out-of-range-while-full case, then deque pops.
        dir_rows = '{
            '{'{MODE_READ,   5'd0,  64'd0}, 1'b1, '{64'd0, 5'd0, ST_RANGE}},
            '{'{MODE_REMOVE, 5'd0,  64'd0}, 1'b1, '{64'd0, 5'd0, ST_RANGE}},
            '{'{MODE_UNUSED, 5'd0,  ONES},  1'b1, '{64'd0, 5'd0, ST_RANGE}},
            '{'{MODE_INSERT, 5'd1,  ONES},  1'b1, '{64'd0, 5'd0, ST_RANGE}},
            '{'{MODE_INSERT, 5'd0,  ONES},  1'b1, '{64'd0, 5'd1, ST_OK}},
            '{'{MODE_INSERT, 5'd1,  64'd0}, 1'b1, '{64'd0, 5'd2, ST_OK}},
            '{'{MODE_READ,   5'd0,  64'd0}, 1'b1, '{ONES,  5'd2, ST_OK}},
            '{'{MODE_INSERT, 5'd31, ONES},  1'b1, '{64'd0, 5'd2, ST_RANGE}},
            '{'{MODE_INSERT, 5'd0,  64'h0123_4567_89AB_CDEF}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd3,  64'hFEDC_BA98_7654_3210}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd2,  64'h8000_0000_0000_0000}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd5,  64'h0000_0000_0000_0001}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd1,  64'hDEAD_BEEF_CAFE_F00D}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd0,  64'h5555_5555_5555_5555}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd8,  64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd4,  64'h0F0F_0F0F_0F0F_0F0F}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd10, 64'hF0F0_F0F0_F0F0_F0F0}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd6,  64'h7FFF_FFFF_FFFF_FFFF}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd0,  64'h1234_5678_9ABC_DEF0}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd13, 64'h0000_FFFF_0000_FFFF}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd7,  64'hFFFF_0000_FFFF_0000}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd15, 64'h3C3C_3C3C_3C3C_3C3C}, 1'b0, '0},
            '{'{MODE_INSERT, 5'd16, ONES},  1'b1, '{64'd0, 5'd16, ST_FULL}},
            '{'{MODE_INSERT, 5'd17, ONES},  1'b1, '{64'd0, 5'd16, ST_RANGE}},
            '{'{MODE_READ,   5'd15, 64'd0}, 1'b0, '0},
            '{'{MODE_REMOVE, 5'd15, 64'd0}, 1'b1, '{64'd0, 5'd15, ST_OK}},
            '{'{MODE_REMOVE, 5'd0,  64'd0}, 1'b1, '{64'd0, 5'd14, ST_OK}}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        drain_responses();

        // Random part in segments: fill-heavy, drain-heavy, balanced and read-heavy
        // mixes so the list swings between empty and full.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:       begin insert_pct = 60; remove_pct = 15; end
                1:       begin insert_pct = 15; remove_pct = 60; end
                2:       begin insert_pct = 35; remove_pct = 35; end
                default: begin insert_pct = 30; remove_pct = 25; end
            endcase
            if (seg >= SEGMENTS - CALM_SEGMENTS)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = 12 * $urandom_range(3);
                rx_stall_pct = 12 * $urandom_range(3);
            end
            for (n = 0; n < SEGMENT_LEN; n++)
                send_request(pick_request(insert_pct, remove_pct), 1'b0, '0);
            if (seg % 5 == 4)
                drain_responses();
        end

        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS indexed_sequence_store_top");
        else
            $display("FAIL indexed_sequence_store_top");
        $finish;
    end

endmodule
